[sv/lcs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Limit calibration sequencer package
// Shared types, register map, command codes and the microcode program of the
// two-axis limit calibration sequencer.
// ---------------------------------------------------------------------------
package lcs_pkg;

    localparam int NUM_REFLECTORS_DEF = 16;
    localparam int PADDR_W            = 5;
    localparam int PDATA_W            = 32;

    // Register indexes (byte address = 4 * index).
    localparam logic [2:0] REG_CYCLES_REQUIRED   = 3'd0;
    localparam logic [2:0] REG_DOUBLE_STEP_CYCLE = 3'd1;
    localparam logic [2:0] REG_STEP_SIZE         = 3'd2;
    localparam logic [2:0] REG_PARK_POSITION     = 3'd3;
    localparam logic [2:0] REG_HOME_ELEVATION    = 3'd4;

    localparam logic [3:0]  RST_CYCLES_REQUIRED   = 4'd3;
    localparam logic [3:0]  RST_DOUBLE_STEP_CYCLE = 4'd2;
    localparam logic [11:0] RST_STEP_SIZE         = 12'd160;
    localparam logic [15:0] RST_PARK_POSITION     = 16'd3200;
    localparam logic [15:0] RST_HOME_ELEVATION    = 16'd6400;

    // Actuator command codes.
    localparam logic [2:0] CMD_IDLE         = 3'd0;
    localparam logic [2:0] CMD_SET_POSITION = 3'd1;
    localparam logic [2:0] CMD_FLASH        = 3'd2;
    localparam logic [2:0] CMD_REBOOT       = 3'd3;
    localparam logic [2:0] CMD_WAKE_UP      = 3'd4;
    localparam logic [2:0] CMD_READ         = 3'd5;
    localparam logic [2:0] CMD_STEP         = 3'd6;

    // Axis status codes.
    localparam logic [2:0] ST_MIN_LIMIT = 3'd1;
    localparam logic [2:0] ST_MAX_LIMIT = 3'd2;
    localparam logic [2:0] ST_END       = 3'd3;
    localparam logic [2:0] ST_END_ALT   = 3'd4;

    localparam logic [3:0] CYCLES_MAX = 4'hF;

    // Microcode program layout.
    localparam int         UPC_W          = 4;
    localparam logic [3:0] UC_ENTRY_LIMIT = 4'd0;
    localparam logic [3:0] UC_ENTRY_HOME  = 4'd5;
    localparam logic [3:0] UC_ENTRY_END   = 4'd6;
    localparam logic [3:0] UC_ENTRY_STEP  = 4'd9;
    localparam logic [3:0] UC_LAST_ADDR   = 4'd9;

    typedef enum logic [1:0] {
        ARG_ZERO,
        ARG_LIMIT,
        ARG_HOME,
        ARG_DELTA
    } arg_sel_e;

    typedef enum logic [1:0] {
        OP_NEXT,
        OP_END,
        OP_END_IF_DISARMED
    } seq_op_e;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_RUN
    } seq_state_e;

    typedef struct packed {
        logic [2:0] cmd;
        arg_sel_e   sel_az;
        arg_sel_e   sel_el;
        seq_op_e    op;
    } ucode_t;

    typedef struct packed {
        logic              mode;
        logic [3:0]        reflector_index;
        logic [2:0]        status_azimuth;
        logic [2:0]        status_elevation;
        logic signed [19:0] position_azimuth;
        logic signed [19:0] position_elevation;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [19:0] arg_azimuth;
        logic signed [19:0] arg_elevation;
        logic               still_calibrating;
        logic [3:0]         cycles_done;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic [3:0]  cycles_required;
        logic [3:0]  double_step_cycle;
        logic [11:0] step_size;
        logic [15:0] park_position;
        logic [15:0] home_elevation;
    } cfg_t;

    // Per-reflector context word.
    typedef struct packed {
        logic       armed;
        logic       az_end;
        logic       el_end;
        logic [3:0] home_cycles;
        logic       dbl_taken;
    } ctx_t;

    function automatic int addr_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    // Control store. The limit run lives at the top; the home run falls
    // through into the single-end run, which in turn falls into the step.
    function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] upc);
        ucode_t w;
        w = '{cmd: CMD_IDLE, sel_az: ARG_ZERO, sel_el: ARG_ZERO, op: OP_END};
        unique case (upc)
            4'd0: w = '{cmd: CMD_SET_POSITION, sel_az: ARG_LIMIT, sel_el: ARG_LIMIT,
                        op: OP_NEXT};
            4'd1: w = '{cmd: CMD_FLASH,   sel_az: ARG_ZERO, sel_el: ARG_ZERO, op: OP_NEXT};
            4'd2: w = '{cmd: CMD_REBOOT,  sel_az: ARG_ZERO, sel_el: ARG_ZERO, op: OP_NEXT};
            4'd3: w = '{cmd: CMD_WAKE_UP, sel_az: ARG_ZERO, sel_el: ARG_ZERO, op: OP_NEXT};
            4'd4: w = '{cmd: CMD_READ,    sel_az: ARG_ZERO, sel_el: ARG_ZERO, op: OP_END};
            4'd5: w = '{cmd: CMD_SET_POSITION, sel_az: ARG_ZERO, sel_el: ARG_HOME,
                        op: OP_NEXT};
            4'd6: w = '{cmd: CMD_FLASH,   sel_az: ARG_ZERO, sel_el: ARG_ZERO, op: OP_NEXT};
            4'd7: w = '{cmd: CMD_REBOOT,  sel_az: ARG_ZERO, sel_el: ARG_ZERO, op: OP_NEXT};
            4'd8: w = '{cmd: CMD_READ,    sel_az: ARG_ZERO, sel_el: ARG_ZERO,
                        op: OP_END_IF_DISARMED};
            4'd9: w = '{cmd: CMD_STEP,    sel_az: ARG_DELTA, sel_el: ARG_DELTA, op: OP_END};
            default: w = '{cmd: CMD_IDLE, sel_az: ARG_ZERO, sel_el: ARG_ZERO, op: OP_END};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

[sv/lcs_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Limit calibration sequencer register bank
// APB-style register file holding the five calibration settings.
// ---------------------------------------------------------------------------
module lcs_cfg (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [lcs_pkg::PADDR_W-1:0] paddr,
    input  wire logic [lcs_pkg::PDATA_W-1:0] pwdata,
    output logic      [lcs_pkg::PDATA_W-1:0] prdata,
    output logic                             pready,
    output lcs_pkg::cfg_t                    cfg
);
    import lcs_pkg::*;

    logic [3:0]  cycles_required_reg;
    logic [3:0]  double_step_cycle_reg;
    logic [11:0] step_size_reg;
    logic [15:0] park_position_reg;
    logic [15:0] home_elevation_reg;
    logic [2:0]  reg_index;
    logic        wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign wr_en     = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cycles_required_reg   <= RST_CYCLES_REQUIRED;
            double_step_cycle_reg <= RST_DOUBLE_STEP_CYCLE;
            step_size_reg         <= RST_STEP_SIZE;
            park_position_reg     <= RST_PARK_POSITION;
            home_elevation_reg    <= RST_HOME_ELEVATION;
        end else if (wr_en) begin
            unique case (reg_index)
                REG_CYCLES_REQUIRED:   cycles_required_reg   <= pwdata[3:0];
                REG_DOUBLE_STEP_CYCLE: double_step_cycle_reg <= pwdata[3:0];
                REG_STEP_SIZE:         step_size_reg         <= pwdata[11:0];
                REG_PARK_POSITION:     park_position_reg     <= pwdata[15:0];
                REG_HOME_ELEVATION:    home_elevation_reg    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            REG_CYCLES_REQUIRED:   prdata = {28'b0, cycles_required_reg};
            REG_DOUBLE_STEP_CYCLE: prdata = {28'b0, double_step_cycle_reg};
            REG_STEP_SIZE:         prdata = {20'b0, step_size_reg};
            REG_PARK_POSITION:     prdata = {16'b0, park_position_reg};
            REG_HOME_ELEVATION:    prdata = {16'b0, home_elevation_reg};
            default:               prdata = '0;
        endcase
    end

    assign cfg = '{cycles_required:   cycles_required_reg,
                   double_step_cycle: double_step_cycle_reg,
                   step_size:         step_size_reg,
                   park_position:     park_position_reg,
                   home_elevation:    home_elevation_reg};

endmodule
`default_nettype wire

[sv/lcs_ctx_mem.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Limit calibration sequencer context store
// One context word per reflector, with a valid bit per entry so that an
// entry never written since reset reads as all zeros.
// ---------------------------------------------------------------------------
module lcs_ctx_mem #(
    parameter int NUM_REFLECTORS = lcs_pkg::NUM_REFLECTORS_DEF
) (
    input  wire logic                                        aclk,
    input  wire logic                                        aresetn,
    input  wire logic                                        rd_en,
    input  wire logic [lcs_pkg::addr_w(NUM_REFLECTORS)-1:0]  rd_addr,
    output lcs_pkg::ctx_t                                    rd_data,
    input  wire logic                                        wr_en,
    input  wire logic [lcs_pkg::addr_w(NUM_REFLECTORS)-1:0]  wr_addr,
    input  lcs_pkg::ctx_t                                    wr_data
);
    import lcs_pkg::*;

    ctx_t                      mem [NUM_REFLECTORS];
    logic [NUM_REFLECTORS-1:0] valid_reg;
    ctx_t                      rd_data_reg;
    logic                      rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule
`default_nettype wire

[sv/lcs_seq.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Limit calibration sequencer control
// Decides the run for one readout, updates the reflector context and steps
// the microcode program to issue the actuator commands one at a time.
// ---------------------------------------------------------------------------
module lcs_seq #(
    parameter int NUM_REFLECTORS = lcs_pkg::NUM_REFLECTORS_DEF
) (
    input  wire logic                                        aclk,
    input  wire logic                                        aresetn,
    input  wire logic                                        s_valid,
    output logic                                             s_ready,
    input  lcs_pkg::in_item_t                                s_item,
    output logic                                             m_valid,
    input  wire logic                                        m_ready,
    output lcs_pkg::out_item_t                               m_item,
    input  lcs_pkg::cfg_t                                    cfg,
    output logic                                             ctx_rd_en,
    output logic      [lcs_pkg::addr_w(NUM_REFLECTORS)-1:0]  ctx_rd_addr,
    input  lcs_pkg::ctx_t                                    ctx_rd_data,
    output logic                                             ctx_wr_en,
    output logic      [lcs_pkg::addr_w(NUM_REFLECTORS)-1:0]  ctx_wr_addr,
    output lcs_pkg::ctx_t                                    ctx_wr_data
);
    import lcs_pkg::*;

    localparam int ADDR_W = addr_w(NUM_REFLECTORS);

    seq_state_e         state_reg, state_next;
    in_item_t           item_reg;
    logic [UPC_W-1:0]   upc_reg, upc_next;
    logic signed [19:0] daz_reg, del_reg;
    logic               still_reg;
    logic [3:0]         cycles_reg;
    logic               lim_az_reg, lim_el_reg;
    logic               m_valid_reg;
    out_item_t          m_item_reg, m_item_next;

    logic               accept, in_range, load, run_go, run_last;
    ucode_t             cw;

    // Decision signals.
    logic               lim_az, lim_el, lim_any, fa, fe, both, at_double;
    logic [3:0]         hc_new;
    logic               arm_new, dbl_new;
    logic signed [19:0] daz, del;
    logic signed [19:0] step_pos, step_neg, dbl_pos, dbl_neg;
    logic [UPC_W-1:0]   entry;
    ctx_t               cur, upd;

    function automatic logic signed [19:0] arg_pick(
        input arg_sel_e           sel,
        input logic               lim,
        input logic signed [19:0] pos,
        input logic signed [19:0] delta,
        input cfg_t               c
    );
        logic signed [19:0] v;
        v = '0;
        unique case (sel)
            ARG_ZERO:  v = '0;
            ARG_LIMIT: v = lim ? $signed({4'b0, c.park_position}) : pos;
            ARG_HOME:  v = $signed({4'b0, c.home_elevation});
            ARG_DELTA: v = delta;
            default:   v = '0;
        endcase
        return v;
    endfunction

    // ---- decision for the readout held in item_reg ----
    always_comb begin
        cur      = ctx_rd_data;
        lim_az   = (item_reg.status_azimuth == ST_MIN_LIMIT) ||
                   (item_reg.status_azimuth == ST_MAX_LIMIT);
        lim_el   = (item_reg.status_elevation == ST_MIN_LIMIT) ||
                   (item_reg.status_elevation == ST_MAX_LIMIT);
        lim_any  = lim_az | lim_el;
        fa       = cur.az_end | (item_reg.status_azimuth == ST_END);
        fe       = cur.el_end | (item_reg.status_elevation == ST_END) ||
                   (item_reg.status_elevation == ST_END_ALT);
        both     = fa & fe;
        step_pos = $signed({8'b0, cfg.step_size});
        step_neg = -step_pos;
        dbl_pos  = $signed({7'b0, cfg.step_size, 1'b0});
        dbl_neg  = -dbl_pos;

        hc_new   = cur.home_cycles;
        arm_new  = cur.armed;
        daz      = fa ? '0 : step_neg;
        del      = fe ? '0 : step_pos;
        entry    = UC_ENTRY_STEP;
        priority if (lim_any) begin
            entry = UC_ENTRY_LIMIT;
        end else if (both) begin
            entry   = UC_ENTRY_HOME;
            hc_new  = (cur.home_cycles == CYCLES_MAX) ? CYCLES_MAX :
                      cur.home_cycles + 4'd1;
            arm_new = (hc_new != cfg.cycles_required);
        end else if (fa) begin
            entry = UC_ENTRY_END;
            daz   = step_pos;
        end else if (fe) begin
            entry = UC_ENTRY_END;
            del   = step_neg;
        end else begin
            entry = UC_ENTRY_STEP;
        end

        at_double = (hc_new == cfg.double_step_cycle);
        if (arm_new && at_double && !cur.dbl_taken) begin
            daz = dbl_pos;
            del = dbl_neg;
        end
        dbl_new = cur.dbl_taken | (arm_new & at_double);

        // Every readout that is not at a limit leaves both end flags clear.
        upd = '{armed: arm_new, az_end: 1'b0, el_end: 1'b0,
                home_cycles: hc_new, dbl_taken: dbl_new};
    end

    assign run_go = (state_reg == ST_DECIDE) && !item_reg.mode && cur.armed;

    // ---- sequencer ----
    assign in_range = int'(s_item.reflector_index) < NUM_REFLECTORS;
    assign cw       = ucode_rom(upc_reg);
    assign run_last = (cw.op == OP_END) || ((cw.op == OP_END_IF_DISARMED) && !still_reg);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (accept && in_range) state_next = ST_DECIDE;
            ST_DECIDE: state_next = run_go ? ST_RUN : ST_IDLE;
            ST_RUN:    if (load && run_last) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready     = (state_reg == ST_IDLE);
        accept      = s_valid & s_ready;
        ctx_rd_en   = accept & in_range;
        ctx_rd_addr = ADDR_W'(s_item.reflector_index);
        ctx_wr_en   = (state_reg == ST_DECIDE) &&
                      (item_reg.mode || (cur.armed && !lim_any));
        ctx_wr_addr = ADDR_W'(item_reg.reflector_index);
        ctx_wr_data = item_reg.mode ?
                      ctx_t'{armed: 1'b1, az_end: 1'b0, el_end: 1'b0,
                             home_cycles: 4'd0, dbl_taken: 1'b0} : upd;
        load        = (state_reg == ST_RUN) && (!m_valid_reg || m_ready);
        upc_next    = (state_reg == ST_DECIDE) ? entry : upc_reg + 1'b1;
        m_item_next = '{command:           cw.cmd,
                        arg_azimuth:       arg_pick(cw.sel_az, lim_az_reg,
                                                    item_reg.position_azimuth,
                                                    daz_reg, cfg),
                        arg_elevation:     arg_pick(cw.sel_el, lim_el_reg,
                                                    item_reg.position_elevation,
                                                    del_reg, cfg),
                        still_calibrating: still_reg,
                        cycles_done:       cycles_reg,
                        last:              run_last};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            upc_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if ((state_reg == ST_DECIDE) || load) begin
                upc_reg <= upc_next;
            end
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_item;
        end
        if (state_reg == ST_DECIDE) begin
            daz_reg    <= daz;
            del_reg    <= del;
            still_reg  <= arm_new;
            cycles_reg <= hc_new;
            lim_az_reg <= lim_az;
            lim_el_reg <= lim_el;
        end
        if (load) begin
            m_item_reg <= m_item_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // ---- checks ----
    a_last_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && load && run_last) |=> (state_reg == ST_IDLE))
        else $error("run did not end after its last command");

    a_no_accept_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> !s_ready)
        else $error("input taken while a run is in flight");

    a_upc_in_program: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (upc_reg <= UC_LAST_ADDR))
        else $error("microcode counter ran past the program");

    a_step_only_armed: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_item_reg.command == CMD_STEP) |->
            (m_item_reg.still_calibrating && m_item_reg.last))
        else $error("step issued for a disarmed reflector or not at run end");

endmodule
`default_nettype wire

[sv/two_axis_limit_calibration_sequencer_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Two-axis limit calibration sequencer
// Per-reflector homing and calibration sequencer: turns positioning readouts
// into runs of actuator commands under a small microcoded control program.
//
//   Channel   Ports                      Carries
//   input     s_valid s_ready s_item     arm request or positioning readout
//   result    m_valid m_ready m_item     one actuator command, last marks run end
//   config    psel penable pwrite ...    five calibration registers
//
// An item is taken while the sequencer is idle; the reflector context is then
// read and updated in the decide state, and the microcode counter issues the
// run's commands (up to five), one per cycle while the result is not stalled;
// an item that causes no command goes back to idle from the decide state. No
// new item is taken until the run has ended. A stalled result holds the counter in place.
// Reset clears all contexts to zero at once through per-entry valid bits.
// ---------------------------------------------------------------------------
module two_axis_limit_calibration_sequencer_unit #(
    parameter int NUM_REFLECTORS = lcs_pkg::NUM_REFLECTORS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  lcs_pkg::in_item_t                s_item,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output lcs_pkg::out_item_t               m_item,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [lcs_pkg::PADDR_W-1:0] paddr,
    input  wire logic [lcs_pkg::PDATA_W-1:0] pwdata,
    output logic      [lcs_pkg::PDATA_W-1:0] prdata,
    output logic                             pready
);
    import lcs_pkg::*;

    localparam int ADDR_W = addr_w(NUM_REFLECTORS);

    cfg_t              cfg;
    logic              ctx_rd_en, ctx_wr_en;
    logic [ADDR_W-1:0] ctx_rd_addr, ctx_wr_addr;
    ctx_t              ctx_rd_data, ctx_wr_data;

    lcs_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lcs_ctx_mem #(
        .NUM_REFLECTORS (NUM_REFLECTORS)
    ) u_ctx (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (ctx_rd_en),
        .rd_addr (ctx_rd_addr),
        .rd_data (ctx_rd_data),
        .wr_en   (ctx_wr_en),
        .wr_addr (ctx_wr_addr),
        .wr_data (ctx_wr_data)
    );

    lcs_seq #(
        .NUM_REFLECTORS (NUM_REFLECTORS)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item),
        .cfg         (cfg),
        .ctx_rd_en   (ctx_rd_en),
        .ctx_rd_addr (ctx_rd_addr),
        .ctx_rd_data (ctx_rd_data),
        .ctx_wr_en   (ctx_wr_en),
        .ctx_wr_addr (ctx_wr_addr),
        .ctx_wr_data (ctx_wr_data)
    );

endmodule
`default_nettype wire

[test/tb_two_axis_limit_calibration_sequencer_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for the two-axis limit calibration sequencer
// Drives arm requests and positioning readouts through the input channel,
// predicts the actuator command runs with a cycle-free model of the per-
// reflector calibration state, and checks every command item field by field.
// Registers are rewritten between phases, with both sides idling at random.
// ---------------------------------------------------------------------------
module tb_two_axis_limit_calibration_sequencer_unit;

    import lcs_pkg::*;

    localparam int NREF        = NUM_REFLECTORS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE      = 20;

    localparam logic MODE_READOUT = 1'b0;
    localparam logic MODE_ARM     = 1'b1;

    // Status codes that mean neither limit nor end on an axis.
    localparam logic [2:0] ST_NONE    = 3'd0;
    localparam logic [2:0] ST_SPARE_5 = 3'd5;
    localparam logic [2:0] ST_SPARE_6 = 3'd6;
    localparam logic [2:0] ST_SPARE_7 = 3'd7;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [PADDR_W-1:0]  paddr   = '0;
    logic [PDATA_W-1:0]  pwdata  = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    two_axis_limit_calibration_sequencer_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 aclk = ~aclk;

    // Calibration settings as the block should hold them.
    logic [3:0]  cfg_cycles_required   = RST_CYCLES_REQUIRED;
    logic [3:0]  cfg_double_step_cycle = RST_DOUBLE_STEP_CYCLE;
    logic [11:0] cfg_step_size         = RST_STEP_SIZE;
    logic [15:0] cfg_park_position     = RST_PARK_POSITION;
    logic [15:0] cfg_home_elevation    = RST_HOME_ELEVATION;

    // Per-reflector calibration context.
    logic       cal_armed   [NREF];
    logic       az_end_seen [NREF];
    logic       el_end_seen [NREF];
    logic [3:0] home_count  [NREF];
    logic       double_done [NREF];

    in_item_t  readout_q[$];
    out_item_t cmd_expected[$];

    int error_count   = 0;
    int cycle_count   = 0;
    int hold_requests = 0;
    int holds_served  = 0;

    task automatic flag_mismatch(input string what);
        if (error_count < 40)
            $display("MISMATCH @%0t: %s", $realtime, what);
        error_count++;
    endtask

    function automatic out_item_t cmd_item(input logic [2:0] c,
                                           input logic signed [19:0] az,
                                           input logic signed [19:0] el);
        out_item_t o;
        o = '0;
        o.command       = c;
        o.arg_azimuth   = az;
        o.arg_elevation = el;
        return o;
    endfunction

    function automatic in_item_t mk(input logic mode, input logic [3:0] idx,
                                    input logic [2:0] saz, input logic [2:0] sel,
                                    input logic [19:0] paz, input logic [19:0] pel);
        in_item_t it;
        it.mode               = mode;
        it.reflector_index    = idx;
        it.status_azimuth     = saz;
        it.status_elevation   = sel;
        it.position_azimuth   = paz;
        it.position_elevation = pel;
        return it;
    endfunction

    // Works out the command run that one accepted item causes.
    task automatic predict_commands(input in_item_t it);
        out_item_t          run[$];
        out_item_t          o;
        logic signed [19:0] step, daz, del, park;
        logic               lim_az, lim_el, at_double;
        int                 r;
        r    = int'(it.reflector_index);
        step = {8'd0, cfg_step_size};
        park = {4'd0, cfg_park_position};
        if (it.mode == MODE_ARM) begin
            cal_armed[r]   = 1'b1;
            az_end_seen[r] = 1'b0;
            el_end_seen[r] = 1'b0;
            home_count[r]  = '0;
            double_done[r] = 1'b0;
            return;
        end
        if (!cal_armed[r])
            return;
        lim_az = (it.status_azimuth == ST_MIN_LIMIT) || (it.status_azimuth == ST_MAX_LIMIT);
        lim_el = (it.status_elevation == ST_MIN_LIMIT) ||
                 (it.status_elevation == ST_MAX_LIMIT);
        if (lim_az || lim_el) begin
            run.push_back(cmd_item(CMD_SET_POSITION, lim_az ? park : it.position_azimuth,
                                   lim_el ? park : it.position_elevation));
            run.push_back(cmd_item(CMD_FLASH, '0, '0));
            run.push_back(cmd_item(CMD_REBOOT, '0, '0));
            run.push_back(cmd_item(CMD_WAKE_UP, '0, '0));
            run.push_back(cmd_item(CMD_READ, '0, '0));
        end else begin
            if (it.status_azimuth == ST_END)
                az_end_seen[r] = 1'b1;
            if (it.status_elevation == ST_END || it.status_elevation == ST_END_ALT)
                el_end_seen[r] = 1'b1;
            daz = az_end_seen[r] ? 20'sd0 : -step;
            del = el_end_seen[r] ? 20'sd0 : step;
            if (az_end_seen[r] && el_end_seen[r]) begin
                az_end_seen[r] = 1'b0;
                el_end_seen[r] = 1'b0;
                run.push_back(cmd_item(CMD_SET_POSITION, '0, {4'd0, cfg_home_elevation}));
                run.push_back(cmd_item(CMD_FLASH, '0, '0));
                run.push_back(cmd_item(CMD_REBOOT, '0, '0));
                run.push_back(cmd_item(CMD_READ, '0, '0));
                if (home_count[r] != CYCLES_MAX)
                    home_count[r]++;
                if (home_count[r] == cfg_cycles_required)
                    cal_armed[r] = 1'b0;
            end else if (az_end_seen[r] || el_end_seen[r]) begin
                run.push_back(cmd_item(CMD_FLASH, '0, '0));
                run.push_back(cmd_item(CMD_REBOOT, '0, '0));
                run.push_back(cmd_item(CMD_READ, '0, '0));
                // The axis that reached its end turns round.
                if (az_end_seen[r])
                    daz = step;
                else
                    del = -step;
                az_end_seen[r] = 1'b0;
                el_end_seen[r] = 1'b0;
            end
            if (cal_armed[r]) begin
                at_double = (home_count[r] == cfg_double_step_cycle);
                if (at_double && !double_done[r]) begin
                    daz = step + step;
                    del = -(step + step);
                end
                run.push_back(cmd_item(CMD_STEP, daz, del));
                if (at_double)
                    double_done[r] = 1'b1;
            end
        end
        foreach (run[i]) begin
            o = run[i];
            o.still_calibrating = cal_armed[r];
            o.cycles_done       = home_count[r];
            o.last              = (i == run.size() - 1);
            cmd_expected.push_back(o);
        end
    endtask

    // Sender: bursts of random length separated by random gaps.
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                predict_commands(s_item);
            if (!s_valid || s_ready) begin
                if (gap_left > 0 || readout_q.size() == 0) begin
                    if (gap_left > 0)
                        gap_left--;
                    s_valid <= 1'b0;
                end else begin
                    s_item  <= readout_q.pop_front();
                    s_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(12, 1);
                        case ($urandom_range(3))
                            0: gap_left = 0;
                            1: gap_left = $urandom_range(2, 1);
                            2: gap_left = $urandom_range(6, 3);
                            default: gap_left = $urandom_range(20, 7);
                        endcase
                    end
                end
            end
        end
    end

    // Receiver: stretches of random stall density, plus the occasional long hold.
    int stretch_left = 0;
    int stall_pct    = 0;
    int hold_left    = 0;

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (cmd_expected.size() == 0) begin
                    flag_mismatch($sformatf("unexpected command item %p", m_item));
                end else begin
                    want = cmd_expected.pop_front();
                    if (m_item.command !== want.command)
                        flag_mismatch($sformatf("command %0d, wanted %0d",
                                                m_item.command, want.command));
                    if (m_item.arg_azimuth !== want.arg_azimuth)
                        flag_mismatch($sformatf("arg_azimuth %0d, wanted %0d",
                                                m_item.arg_azimuth, want.arg_azimuth));
                    if (m_item.arg_elevation !== want.arg_elevation)
                        flag_mismatch($sformatf("arg_elevation %0d, wanted %0d",
                                                m_item.arg_elevation, want.arg_elevation));
                    if (m_item.still_calibrating !== want.still_calibrating)
                        flag_mismatch($sformatf("still_calibrating %0b, wanted %0b",
                                                m_item.still_calibrating,
                                                want.still_calibrating));
                    if (m_item.cycles_done !== want.cycles_done)
                        flag_mismatch($sformatf("cycles_done %0d, wanted %0d",
                                                m_item.cycles_done, want.cycles_done));
                    if (m_item.last !== want.last)
                        flag_mismatch($sformatf("last %0b, wanted %0b",
                                                m_item.last, want.last));
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (hold_requests != holds_served) begin
                holds_served++;
                hold_left = LONG_HOLD;
                m_ready <= 1'b0;
            end else begin
                if (stretch_left == 0) begin
                    stretch_left = $urandom_range(40, 5);
                    case ($urandom_range(3))
                        0: stall_pct = 0;
                        1: stall_pct = 25;
                        2: stall_pct = 50;
                        default: stall_pct = 80;
                    endcase
                end
                stretch_left--;
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // A register write followed by a read-back of the same register.
    task automatic write_register(input logic [2:0] idx, input logic [31:0] val);
        logic [31:0] want;
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        case (idx)
            REG_CYCLES_REQUIRED: begin
                cfg_cycles_required = val[3:0];
                want = {28'd0, cfg_cycles_required};
            end
            REG_DOUBLE_STEP_CYCLE: begin
                cfg_double_step_cycle = val[3:0];
                want = {28'd0, cfg_double_step_cycle};
            end
            REG_STEP_SIZE: begin
                cfg_step_size = val[11:0];
                want = {20'd0, cfg_step_size};
            end
            REG_PARK_POSITION: begin
                cfg_park_position = val[15:0];
                want = {16'd0, cfg_park_position};
            end
            REG_HOME_ELEVATION: begin
                cfg_home_elevation = val[15:0];
                want = {16'd0, cfg_home_elevation};
            end
            default: want = '0;
        endcase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== want)
            flag_mismatch($sformatf("register %0d reads %0h, wanted %0h", idx, prdata, want));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_settings(input logic [3:0] cyc, input logic [3:0] dbl,
                                  input logic [11:0] step, input logic [15:0] park,
                                  input logic [15:0] home);
        write_register(REG_CYCLES_REQUIRED, {28'd0, cyc});
        write_register(REG_DOUBLE_STEP_CYCLE, {28'd0, dbl});
        write_register(REG_STEP_SIZE, {20'd0, step});
        write_register(REG_PARK_POSITION, {16'd0, park});
        write_register(REG_HOME_ELEVATION, {16'd0, home});
    endtask

    // Waits until every item is taken and every command has come, then lets
    // the block finish any item that causes no command.
    task automatic wait_idle();
        while (readout_q.size() != 0 || s_valid)
            @(posedge aclk);
        while (cmd_expected.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Mostly arm-then-readout sequences on one reflector, with some noise.
    task automatic queue_phase(input int n_items);
        int         queued, k, pick;
        logic [3:0] r;
        logic [2:0] saz, sel;
        queued = 0;
        while (queued < n_items) begin
            if ($urandom_range(99) < 15) begin
                readout_q.push_back(mk(1'($urandom_range(1)), 4'($urandom_range(15)),
                                       3'($urandom_range(7)), 3'($urandom_range(7)),
                                       20'($urandom_range(20'hFFFFF)),
                                       20'($urandom_range(20'hFFFFF))));
                queued++;
            end else begin
                r = ($urandom_range(9) < 7) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
                readout_q.push_back(mk(MODE_ARM, r, 3'($urandom_range(7)),
                                       3'($urandom_range(7)),
                                       20'($urandom_range(20'hFFFFF)),
                                       20'($urandom_range(20'hFFFFF))));
                k = $urandom_range(8, 3);
                repeat (k) begin
                    pick = $urandom_range(19);
                    if (pick < 9)
                        saz = ST_END;
                    else if (pick < 11)
                        saz = $urandom_range(1) ? ST_MIN_LIMIT : ST_MAX_LIMIT;
                    else
                        saz = 3'($urandom_range(7));
                    pick = $urandom_range(19);
                    if (pick < 9)
                        sel = $urandom_range(1) ? ST_END : ST_END_ALT;
                    else if (pick < 11)
                        sel = $urandom_range(1) ? ST_MIN_LIMIT : ST_MAX_LIMIT;
                    else
                        sel = 3'($urandom_range(7));
                    readout_q.push_back(mk(MODE_READOUT, r, saz, sel,
                                           20'($urandom_range(20'hFFFFF)),
                                           20'($urandom_range(20'hFFFFF))));
                end
                queued += k + 1;
            end
        end
    endtask

    initial begin
        for (int i = 0; i < NREF; i++) begin
            cal_armed[i]   = 1'b0;
            az_end_seen[i] = 1'b0;
            el_end_seen[i] = 1'b0;
            home_count[i]  = '0;
            double_done[i] = 1'b0;
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed run on the reset settings: reflector 0 walked through every kind
        // of readout up to the end of its calibration, then reflectors 15 and 9.
        readout_q.push_back(mk(MODE_READOUT, 4'd0, ST_END, ST_END, 20'h00000, 20'h00000));
        readout_q.push_back(mk(MODE_ARM, 4'd0, ST_NONE, ST_NONE, 20'h00000, 20'h00000));
        readout_q.push_back(mk(MODE_READOUT, 4'd0, ST_NONE, ST_NONE, 20'h7FFFF, 20'h80000));
        readout_q.push_back(mk(MODE_READOUT, 4'd0, ST_MIN_LIMIT, ST_SPARE_5,
                               20'h12345, 20'h80000));
        readout_q.push_back(mk(MODE_READOUT, 4'd0, ST_SPARE_7, ST_MAX_LIMIT,
                               20'h80000, 20'h7FFFF));
        readout_q.push_back(mk(MODE_READOUT, 4'd0, ST_MAX_LIMIT, ST_MIN_LIMIT,
                               20'hFFFFF, 20'h00001));
        readout_q.push_back(mk(MODE_READOUT, 4'd0, ST_END, ST_SPARE_6, 20'h00000, 20'h00000));
        readout_q.push_back(mk(MODE_READOUT, 4'd0, ST_END_ALT, ST_END_ALT,
                               20'h00000, 20'h00000));
        readout_q.push_back(mk(MODE_READOUT, 4'd0, ST_END, ST_END, 20'h00000, 20'h00000));
        readout_q.push_back(mk(MODE_READOUT, 4'd0, ST_END, ST_END_ALT, 20'h00000, 20'h00000));
        readout_q.push_back(mk(MODE_READOUT, 4'd0, ST_NONE, ST_SPARE_7, 20'h00000, 20'h00000));
        readout_q.push_back(mk(MODE_READOUT, 4'd0, ST_END, ST_END, 20'h00000, 20'h00000));
        readout_q.push_back(mk(MODE_READOUT, 4'd0, ST_NONE, ST_NONE, 20'h00000, 20'h00000));
        readout_q.push_back(mk(MODE_ARM, 4'd15, ST_SPARE_7, ST_SPARE_7, 20'hFFFFF, 20'hFFFFF));
        readout_q.push_back(mk(MODE_READOUT, 4'd15, ST_END, ST_END, 20'h80000, 20'h7FFFF));
        readout_q.push_back(mk(MODE_ARM, 4'd15, ST_NONE, ST_NONE, 20'h00000, 20'h00000));
        readout_q.push_back(mk(MODE_READOUT, 4'd15, ST_SPARE_5, ST_NONE,
                               20'h80000, 20'h80000));
        readout_q.push_back(mk(MODE_READOUT, 4'd15, ST_END, ST_END, 20'h7FFFF, 20'h7FFFF));
        readout_q.push_back(mk(MODE_READOUT, 4'd9, ST_MIN_LIMIT, ST_NONE,
                               20'h00000, 20'h00000));
        wait_idle();

        // Lowest settings: one cycle ends calibration, the doubled step comes first.
        apply_settings(4'd1, 4'd0, 12'd0, 16'd0, 16'd0);
        queue_phase(18);
        wait_idle();

        // Highest settings: calibration never ends before the count saturates.
        apply_settings(4'd15, 4'd15, 12'd4095, 16'hFFFF, 16'hFFFF);
        queue_phase(18);
        wait_idle();

        // The receiver holds off while the sender keeps offering items.
        apply_settings(4'($urandom_range(4, 1)), 4'($urandom_range(3)),
                       12'($urandom_range(4095)),
                       16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)));
        queue_phase(18);
        hold_requests++;
        wait_idle();

        apply_settings(4'($urandom_range(4, 1)), 4'($urandom_range(3)),
                       12'($urandom_range(4095)),
                       16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)));
        queue_phase(18);
        wait_idle();

        apply_settings(RST_CYCLES_REQUIRED, RST_DOUBLE_STEP_CYCLE, RST_STEP_SIZE,
                       RST_PARK_POSITION, RST_HOME_ELEVATION);
        queue_phase(18);
        wait_idle();

        if (cmd_expected.size() != 0)
            flag_mismatch($sformatf("%0d command items never arrived", cmd_expected.size()));
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[two_axis_limit_calibration_sequencer_unit.f]
sv/lcs_pkg.sv
sv/lcs_cfg.sv
sv/lcs_ctx_mem.sv
sv/lcs_seq.sv
sv/two_axis_limit_calibration_sequencer_unit.sv
test/tb_two_axis_limit_calibration_sequencer_unit.sv
